>>> rtl/dbc_pkg.sv
// Shared types and constants for the Dalitz boundary check.
package dbc_pkg;

    localparam int unsigned MASS_W = 32;   // port and register width, Q8.24 GeV^2
    localparam int unsigned MAG_W  = 34;   // magnitude of the energy and momentum terms
    localparam int unsigned WIDE_W = 68;   // magnitude of D, X and Y
    localparam int unsigned HALF_W = 34;   // limb width for the wide squares
    localparam int unsigned PROD_W = 136;  // exact width of D^2 and X*Y

    typedef logic [MASS_W-1:0] mass_t;
    typedef logic [WIDE_W-1:0] wide_t;

    localparam logic [2:0] REG_DAUGHTER1 = 3'd0;
    localparam logic [2:0] REG_DAUGHTER2 = 3'd1;
    localparam logic [2:0] REG_DAUGHTER3 = 3'd2;
    localparam logic [2:0] REG_PARENT    = 3'd3;
    localparam logic [2:0] REG_BOX13_MIN = 3'd4;
    localparam logic [2:0] REG_BOX13_MAX = 3'd5;
    localparam logic [2:0] REG_BOX23_MIN = 3'd6;
    localparam logic [2:0] REG_BOX23_MAX = 3'd7;

    typedef struct packed {
        logic valid;
        logic ok;
    } stage_ctl_t;

endpackage

>>> rtl/dbc_if.sv
// Valid/ready channel interfaces for candidate points and decisions.
interface dbc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] pair13_sq;
    logic [31:0] pair23_sq;
    modport source (output valid, output command, output pair13_sq, output pair23_sq,
                    input ready);
    modport sink (input valid, input command, input pair13_sq, input pair23_sq,
                  output ready);
endinterface

interface dbc_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    modport source (output valid, output inside_res, input ready);
    modport sink (input valid, input inside_res, output ready);
endinterface

>>> rtl/dalitz_boundary_check_core.sv
// Top level of the pipelined Dalitz plot boundary check.
// Each transfer on in_ch carries one candidate point (m13^2, m23^2, command) and yields
// exactly one decision on out_ch from the output register at the end of the pipe. The
// pipeline takes one point per cycle; the whole pipe advances together whenever the
// output register is empty or being taken, so throughput is one point per cycle and
// a stall on out_ch holds every stage in place. The depth is set by the exact 136-bit
// compare D^2 < X*Y: three stages form the signed energy/momentum terms and their
// 34x34 products, two reduce them to D, X and Y, and three more square D, form
// X*Y from 34-bit limbs and make the final compare. Decisions are exact and independent
// of the binary point position. Configuration registers (masses and box limits) are
// written through cfg_we/cfg_index/cfg_data and must only change while the pipe is
// empty; all reset to zero, which makes every point read as outside.
module dalitz_boundary_check_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  dbc_pkg::mass_t      cfg_data,
    dbc_in_if.sink              in_ch,
    dbc_out_if.source           out_ch
);
    import dbc_pkg::*;

    // Configuration registers.
    mass_t m1_reg, m2_reg, m3_reg, parent_reg;
    mass_t box13_min_reg, box13_max_reg, box23_min_reg, box23_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg        <= '0;
            m2_reg        <= '0;
            m3_reg        <= '0;
            parent_reg    <= '0;
            box13_min_reg <= '0;
            box13_max_reg <= '0;
            box23_min_reg <= '0;
            box23_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DAUGHTER1: m1_reg        <= cfg_data;
                REG_DAUGHTER2: m2_reg        <= cfg_data;
                REG_DAUGHTER3: m3_reg        <= cfg_data;
                REG_PARENT:    parent_reg    <= cfg_data;
                REG_BOX13_MIN: box13_min_reg <= cfg_data;
                REG_BOX13_MAX: box13_max_reg <= cfg_data;
                REG_BOX23_MIN: box23_min_reg <= cfg_data;
                REG_BOX23_MAX: box23_max_reg <= cfg_data;
                default:       m1_reg        <= m1_reg;
            endcase
        end
    end

    // Advance the whole pipe when the output register is free or being taken.
    logic en;
    logic out_valid;
    assign en          = !out_valid || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: select outer/inner coordinate, box test, signed energy terms.
    mass_t              s_sel, t_sel, lo_sel, hi_sel, ma_sel, mb_sel;
    logic signed [34:0] a_next, b_next, t_next;
    logic               box_next;

    always_comb
    begin
        if (in_ch.command)
        begin
            s_sel  = in_ch.pair23_sq;
            t_sel  = in_ch.pair13_sq;
            lo_sel = box23_min_reg;
            hi_sel = box23_max_reg;
            ma_sel = m2_reg;
            mb_sel = m1_reg;
        end
        else
        begin
            s_sel  = in_ch.pair13_sq;
            t_sel  = in_ch.pair23_sq;
            lo_sel = box13_min_reg;
            hi_sel = box13_max_reg;
            ma_sel = m1_reg;
            mb_sel = m2_reg;
        end
        // A = s - ma + m3, B = P - s - mb, T = t - mb - m3
        a_next   = $signed({3'b0, s_sel}) - $signed({3'b0, ma_sel}) + $signed({3'b0, m3_reg});
        b_next   = $signed({3'b0, parent_reg}) - $signed({3'b0, s_sel})
                 - $signed({3'b0, mb_sel});
        t_next   = $signed({3'b0, t_sel}) - $signed({3'b0, mb_sel}) - $signed({3'b0, m3_reg});
        box_next = (s_sel > lo_sel) && (s_sel < hi_sel);
    end

    stage_ctl_t         s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    logic signed [34:0] s1_a_reg, s1_b_reg, s1_t_reg;
    mass_t              s1_s_reg, s2_s_reg;
    logic               s1_cmd_reg, s2_cmd_reg;

    // Stage 2: magnitudes and signs.
    logic [MAG_W-1:0]   s2_am_reg, s2_bm_reg, s2_tm_reg;
    logic               s2_na_reg, s2_nb_reg, s2_nt_reg;
    logic [34:0]        a_neg, b_neg, t_neg;

    assign a_neg = -s1_a_reg;
    assign b_neg = -s1_b_reg;
    assign t_neg = -s1_t_reg;

    // Stage 3: products.
    logic [WIDE_W-1:0]  s3_a2_reg, s3_b2_reg, s3_ab_reg;
    logic [63:0]        s3_s3m_reg, s3_sbm_reg;
    logic [65:0]        s3_st_reg;
    logic               s3_same_reg;
    mass_t              mb_s2;

    assign mb_s2 = s2_cmd_reg ? m1_reg : m2_reg;

    // Stage 4: X, Y and the two candidates for |D|.
    logic [WIDE_W:0]    s4_x_reg, s4_y_reg, s4_dif_reg;
    logic [WIDE_W-1:0]  s4_sum_reg;
    logic               s4_same_reg;
    logic [66:0]        st2;
    logic [WIDE_W:0]    dif_neg;

    assign st2     = {s3_st_reg, 1'b0};
    assign dif_neg = -s4_dif_reg;

    // Stage 5: positivity of X and Y, and |D|.
    wide_t              s5_d_reg, s5_x_reg, s5_y_reg;
    logic               x_pos, y_pos;

    assign x_pos = !s4_x_reg[WIDE_W] && (|s4_x_reg[WIDE_W-1:0]);
    assign y_pos = !s4_y_reg[WIDE_W] && (|s4_y_reg[WIDE_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= '{valid: in_ch.valid, ok: box_next};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            // Mark the point outside if either momentum argument is not positive.
            s5_ctl_reg <= '{valid: s4_ctl_reg.valid, ok: s4_ctl_reg.ok && x_pos && y_pos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg   <= a_next;
            s1_b_reg   <= b_next;
            s1_t_reg   <= t_next;
            s1_s_reg   <= s_sel;
            s1_cmd_reg <= in_ch.command;

            s2_am_reg  <= s1_a_reg[34] ? a_neg[MAG_W-1:0] : s1_a_reg[MAG_W-1:0];
            s2_bm_reg  <= s1_b_reg[34] ? b_neg[MAG_W-1:0] : s1_b_reg[MAG_W-1:0];
            s2_tm_reg  <= s1_t_reg[34] ? t_neg[MAG_W-1:0] : s1_t_reg[MAG_W-1:0];
            s2_na_reg  <= s1_a_reg[34];
            s2_nb_reg  <= s1_b_reg[34];
            s2_nt_reg  <= s1_t_reg[34];
            s2_s_reg   <= s1_s_reg;
            s2_cmd_reg <= s1_cmd_reg;

            s3_a2_reg   <= {{MAG_W{1'b0}}, s2_am_reg} * {{MAG_W{1'b0}}, s2_am_reg};
            s3_b2_reg   <= {{MAG_W{1'b0}}, s2_bm_reg} * {{MAG_W{1'b0}}, s2_bm_reg};
            s3_ab_reg   <= {{MAG_W{1'b0}}, s2_am_reg} * {{MAG_W{1'b0}}, s2_bm_reg};
            s3_s3m_reg  <= {32'b0, s2_s_reg} * {32'b0, m3_reg};
            s3_sbm_reg  <= {32'b0, s2_s_reg} * {32'b0, mb_s2};
            s3_st_reg   <= {34'b0, s2_s_reg} * {32'b0, s2_tm_reg};
            // D = 2sT - AB: same signs subtract magnitudes, else add them.
            s3_same_reg <= s2_nt_reg == (s2_na_reg ^ s2_nb_reg);

            s4_x_reg    <= {1'b0, s3_a2_reg} - {3'b0, s3_s3m_reg, 2'b0};
            s4_y_reg    <= {1'b0, s3_b2_reg} - {3'b0, s3_sbm_reg, 2'b0};
            s4_dif_reg  <= {2'b0, st2} - {1'b0, s3_ab_reg};
            s4_sum_reg  <= {1'b0, st2} + s3_ab_reg;
            s4_same_reg <= s3_same_reg;

            s5_x_reg <= s4_x_reg[WIDE_W-1:0];
            s5_y_reg <= s4_y_reg[WIDE_W-1:0];
            if (s4_same_reg)
                s5_d_reg <= s4_dif_reg[WIDE_W] ? dif_neg[WIDE_W-1:0] : s4_dif_reg[WIDE_W-1:0];
            else
                s5_d_reg <= s4_sum_reg;
        end
    end

    // Stages 6 to 8: exact squares and compare; the last stage is the output register.
    logic decision;

    dbc_square_cmp u_square_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl        (s5_ctl_reg),
        .d_mag      (s5_d_reg),
        .x_val      (s5_x_reg),
        .y_val      (s5_y_reg),
        .res_valid  (out_valid),
        .res_inside (decision)
    );

    assign out_ch.valid      = out_valid;
    assign out_ch.inside_res = decision;

endmodule

>>> rtl/dbc_square_cmp.sv
// Limb-split wide squares and exact final compare D^2 < X*Y.
module dbc_square_cmp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  dbc_pkg::stage_ctl_t ctl,
    input  dbc_pkg::wide_t     d_mag,
    input  dbc_pkg::wide_t     x_val,
    input  dbc_pkg::wide_t     y_val,
    output logic               res_valid,
    output logic               res_inside
);
    import dbc_pkg::*;

    logic [HALF_W-1:0] dh, dl, xh, xl, yh, yl;
    stage_ctl_t        p1_ctl_reg, p2_ctl_reg;
    logic [WIDE_W-1:0] dhh_reg, dhl_reg, dll_reg, xhh_reg, xhl_reg, xlh_reg, xll_reg;
    logic [PROD_W-1:0] dd_reg, xy_reg, dd_next, xy_next;
    logic [WIDE_W:0]   cross_sum;
    logic              valid_reg, inside_reg;

    assign dh = d_mag[WIDE_W-1:HALF_W];
    assign dl = d_mag[HALF_W-1:0];
    assign xh = x_val[WIDE_W-1:HALF_W];
    assign xl = x_val[HALF_W-1:0];
    assign yh = y_val[WIDE_W-1:HALF_W];
    assign yl = y_val[HALF_W-1:0];

    assign cross_sum = {1'b0, xhl_reg} + {1'b0, xlh_reg};
    assign dd_next = {dhh_reg, {WIDE_W{1'b0}}}
                   + {{(HALF_W-1){1'b0}}, dhl_reg, {(HALF_W+1){1'b0}}}
                   + {{WIDE_W{1'b0}}, dll_reg};
    assign xy_next = {xhh_reg, {WIDE_W{1'b0}}}
                   + {{(HALF_W-1){1'b0}}, cross_sum, {HALF_W{1'b0}}}
                   + {{WIDE_W{1'b0}}, xll_reg};

    // Control: valid and admissibility flags travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
            p2_ctl_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            p1_ctl_reg <= ctl;
            p2_ctl_reg <= p1_ctl_reg;
            valid_reg  <= p2_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Partial products, one 34x34 multiply each.
            dhh_reg <= {{HALF_W{1'b0}}, dh} * {{HALF_W{1'b0}}, dh};
            dhl_reg <= {{HALF_W{1'b0}}, dh} * {{HALF_W{1'b0}}, dl};
            dll_reg <= {{HALF_W{1'b0}}, dl} * {{HALF_W{1'b0}}, dl};
            xhh_reg <= {{HALF_W{1'b0}}, xh} * {{HALF_W{1'b0}}, yh};
            xhl_reg <= {{HALF_W{1'b0}}, xh} * {{HALF_W{1'b0}}, yl};
            xlh_reg <= {{HALF_W{1'b0}}, xl} * {{HALF_W{1'b0}}, yh};
            xll_reg <= {{HALF_W{1'b0}}, xl} * {{HALF_W{1'b0}}, yl};
            dd_reg  <= dd_next;
            xy_reg  <= xy_next;
            inside_reg <= p2_ctl_reg.ok && (dd_reg < xy_reg);
        end
    end

    assign res_valid  = valid_reg;
    assign res_inside = inside_reg;

endmodule
